// ----- hdl/srsk_pkg.sv -----
// Types and constants shared by the stable record sorter.
`timescale 1ns / 1ps
`default_nettype none
package srsk_pkg;

    localparam int KEY_W = 64;
    localparam int TAG_W = 6;
    localparam int MODE_W = 3;
    localparam int DATE_W = 40;

    localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CODE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FROM = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TO = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } srsk_entry_t;

    typedef struct packed {
        logic insert;
        logic drain;
    } srsk_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } srsk_state_t;

endpackage
`default_nettype wire

// ----- hdl/srsk_keygen.sv -----
// Builds the sort key of an incoming record from the selected sort mode.
`timescale 1ns / 1ps
`default_nettype none
module srsk_keygen #(
    parameter int KEY_CHARS = 8
) (
    input  wire logic [srsk_pkg::MODE_W-1:0] mode,
    input  wire logic [13:0]                 year,
    input  wire logic [3:0]                  month,
    input  wire logic [4:0]                  day,
    input  wire logic [4:0]                  dep_hour,
    input  wire logic [5:0]                  dep_minute,
    input  wire logic [5:0]                  dep_second,
    input  wire logic [63:0]                 code_text,
    input  wire logic [63:0]                 from_text,
    input  wire logic [63:0]                 to_text,
    output logic      [srsk_pkg::KEY_W-1:0]  key
);
    import srsk_pkg::*;

    logic [63:0] text_sel;
    logic [63:0] text_key;
    logic        alive;

    always_comb
    begin
        unique case (mode)
            MODE_FROM: text_sel = from_text;
            MODE_TO:   text_sel = to_text;
            default:   text_sel = code_text;
        endcase
    end

    // A zero byte ends the text; bytes beyond KEY_CHARS never count.
    always_comb
    begin
        text_key = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (text_sel[56 - 8 * i +: 8] == 8'd0 || i >= KEY_CHARS)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                text_key[56 - 8 * i +: 8] = text_sel[56 - 8 * i +: 8];
            end
        end
    end

    always_comb
    begin
        unique case (mode)
            MODE_DATE:
                key = {{(KEY_W - DATE_W){1'b0}}, year, month, day,
                       dep_hour, dep_minute, dep_second};
            MODE_CODE, MODE_FROM, MODE_TO:
                key = text_key;
            default:
                key = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/srsk_cell.sv -----
// One cell of the insertion chain: holds one record and passes it to a neighbour.
`timescale 1ns / 1ps
`default_nettype none
module srsk_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire srsk_pkg::srsk_ctrl_t           ctrl,
    input  wire logic [srsk_pkg::KEY_W-1:0]     new_key,
    input  wire logic [srsk_pkg::TAG_W-1:0]     new_tag,
    input  wire srsk_pkg::srsk_entry_t          prev_entry,
    input  wire logic                           prev_gt,
    input  wire srsk_pkg::srsk_entry_t          next_entry,
    output srsk_pkg::srsk_entry_t               entry,
    output logic                                gt
);
    import srsk_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;

    // The new record goes after every stored record with an equal key.
    assign gt = valid_reg && (new_key < key_reg);

    always_comb
    begin
        priority if (ctrl.drain)
        begin
            valid_next = next_entry.valid;
            key_next = next_entry.key;
            tag_next = next_entry.tag;
        end
        else if (ctrl.insert && prev_gt)
        begin
            valid_next = prev_entry.valid;
            key_next = prev_entry.key;
            tag_next = prev_entry.tag;
        end
        else if (ctrl.insert && (gt || (!valid_reg && prev_entry.valid)))
        begin
            valid_next = 1'b1;
            key_next = new_key;
            tag_next = new_tag;
        end
        else
        begin
            valid_next = valid_reg;
            key_next = key_reg;
            tag_next = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign entry = '{valid: valid_reg, key: key_reg, tag: tag_reg};

endmodule
`default_nettype wire

// ----- hdl/stable_record_sort_by_key.sv -----
// Top level of the stable record sorter: key generation, cell chain and control.
//
// Records enter on the s_ channel, one item per cycle while s_tready is high.
// Each accepted record is placed in the cell chain in the same cycle: its key
// is compared against every stored key at once and the larger records move
// one cell along. The key is chosen by the sort mode register at the moment
// the record arrives; equal keys keep their arrival order. Records arriving
// when all MAX_RECORDS cells are full are dropped and the overflow flag
// (m_tuser) is raised on every result. An item with s_tlast high ends the
// set. From the next cycle the chain drains through cell 0 on the m_ channel,
// one tag per cycle while m_tready is high, m_tlast on the final one. s_tready
// is low while the set is being emitted. When the receiver holds m_tready low
// the chain simply holds its contents. After reset the chain is empty, the
// flag is clear, the sort mode is zero and the block is ready to load.
`timescale 1ns / 1ps
`default_nettype none
module stable_record_sort_by_key #(
    parameter int MAX_RECORDS = 64,
    parameter int KEY_CHARS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_wr_data,   // sort_mode
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // year, month, day, dep_hour, dep_minute, dep_second, code_text,
    // from_text, to_text, record_tag, then two zero bits
    input  wire logic [239:0] s_tdata,
    input  wire logic         s_tlast,       // last_record
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [7:0]   m_tdata,       // sorted_tag, then two zero bits
    output logic              m_tlast,       // last_out
    output logic      [0:0]   m_tuser        // overflowed
);
    import srsk_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic              overflow_reg;
    logic              overflow_next;
    srsk_state_t       state_reg;
    srsk_state_t       state_next;

    logic              s_fire;
    logic              m_fire;
    logic              full;
    logic [KEY_W-1:0]  new_key;
    logic [TAG_W-1:0]  new_tag;
    srsk_ctrl_t        ctrl;

    srsk_entry_t       entry_w [MAX_RECORDS];
    logic              gt_w [MAX_RECORDS];
    srsk_entry_t       empty_entry;
    srsk_entry_t       head_entry;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign full = entry_w[MAX_RECORDS-1].valid;
    assign new_tag = s_tdata[237:232];
    assign empty_entry = '{valid: 1'b0, key: '0, tag: '0};
    assign head_entry = '{valid: 1'b1, key: '0, tag: '0};

    srsk_keygen #(
        .KEY_CHARS(KEY_CHARS)
    ) u_keygen (
        .mode(mode_reg),
        .year(s_tdata[13:0]),
        .month(s_tdata[17:14]),
        .day(s_tdata[22:18]),
        .dep_hour(s_tdata[27:23]),
        .dep_minute(s_tdata[33:28]),
        .dep_second(s_tdata[39:34]),
        .code_text(s_tdata[103:40]),
        .from_text(s_tdata[167:104]),
        .to_text(s_tdata[231:168]),
        .key(new_key)
    );

    for (genvar i = 0; i < MAX_RECORDS; i++)
    begin : g_cell
        srsk_entry_t prev_e;
        logic        prev_g;
        srsk_entry_t next_e;

        if (i == 0)
        begin : g_first
            assign prev_e = head_entry;
            assign prev_g = 1'b0;
        end
        else
        begin : g_inner
            assign prev_e = entry_w[i-1];
            assign prev_g = gt_w[i-1];
        end

        if (i == MAX_RECORDS - 1)
        begin : g_end
            assign next_e = empty_entry;
        end
        else
        begin : g_mid
            assign next_e = entry_w[i+1];
        end

        srsk_cell u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .ctrl(ctrl),
            .new_key(new_key),
            .new_tag(new_tag),
            .prev_entry(prev_e),
            .prev_gt(prev_g),
            .next_entry(next_e),
            .entry(entry_w[i]),
            .gt(gt_w[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_fire && s_tlast)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_fire && m_tlast)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_LOAD: s_tready = 1'b1;
            ST_EMIT: m_tvalid = 1'b1;
            default: s_tready = 1'b0;
        endcase
    end

    assign ctrl = '{insert: s_fire && !full, drain: m_fire};

    always_comb
    begin
        priority if (m_fire && m_tlast)
        begin
            overflow_next = 1'b0;
        end
        else if (s_fire && full)
        begin
            overflow_next = 1'b1;
        end
        else
        begin
            overflow_next = overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            overflow_reg <= 1'b0;
            mode_reg <= MODE_NONE;
        end
        else
        begin
            state_reg <= state_next;
            overflow_reg <= overflow_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    assign m_tdata = {2'b00, entry_w[0].tag};
    assign m_tlast = !entry_w[1].valid;
    assign m_tuser = overflow_reg;

    a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
        entry_w[1].valid |-> entry_w[0].valid)
        else $error("cell chain has a gap at its head");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> entry_w[0].valid)
        else $error("emitting from an empty chain");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("loading and emitting at once");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && m_tlast) |=> (s_tready && !entry_w[0].valid && !m_tuser[0]))
        else $error("chain or flag not cleared after the final item");

endmodule
`default_nettype wire
